// ----- rtl/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// Scheduled task trigger package
// Register indexes, field widths and the structures shared by the trigger unit.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

	// Field widths
	localparam int unsigned SecW    = 32;
	localparam int unsigned DayW    = 3;
	localparam int unsigned RepW    = 17;
	localparam int unsigned MaskW   = 7;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDatW = 32;

	// Stream payload widths, padded to whole bytes
	localparam int unsigned InDataW  = 40;
	localparam int unsigned OutDataW = 56;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_TASK_ENABLE       = 3'd0,
		REG_LIMIT_ENABLES     = 3'd1,
		REG_WINDOW_START      = 3'd2,
		REG_WINDOW_END        = 3'd3,
		REG_WEEKDAY_MASK      = 3'd4,
		REG_REPEAT_COUNT      = 3'd5,
		REG_CADENCE_SECONDS   = 3'd6,
		REG_START_IMMEDIATELY = 3'd7
	} cfg_reg_t;

	// Input actions
	typedef enum logic {
		ACT_EVALUATE = 1'b0,
		ACT_RESTART  = 1'b1
	} action_t;

	// Configuration register set
	typedef struct packed {
		logic                   task_enable;
		logic [1:0]             limit_enables;
		logic [SecW-1:0]        window_start;
		logic [SecW-1:0]        window_end;
		logic [MaskW-1:0]       weekday_mask;
		logic signed [RepW-1:0] repeat_count;
		logic [SecW-1:0]        cadence_seconds;
		logic                   start_immediately;
	} cfg_t;

	// One input item
	typedef struct packed {
		action_t         action;
		logic [SecW-1:0] current_seconds;
		logic [DayW-1:0] day_of_week;
	} item_t;

	// One result item
	typedef struct packed {
		logic                   fire;
		logic                   in_window;
		logic signed [RepW-1:0] repeats_left;
		logic [SecW-1:0]        fires_done;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/stt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Trigger configuration registers
// Decodes the configuration write channel into the register set.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [stt_pkg::CfgIdxW-1:0]  wr_index,
	input  wire logic [stt_pkg::CfgDatW-1:0]  wr_data,
	output stt_pkg::cfg_t                     cfg
);

	stt_pkg::cfg_t cfg_q;

	// Write the addressed register on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (stt_pkg::cfg_reg_t'(wr_index))
				stt_pkg::REG_TASK_ENABLE:       cfg_q.task_enable       <= wr_data[0];
				stt_pkg::REG_LIMIT_ENABLES:     cfg_q.limit_enables     <= wr_data[1:0];
				stt_pkg::REG_WINDOW_START:      cfg_q.window_start      <= wr_data;
				stt_pkg::REG_WINDOW_END:        cfg_q.window_end        <= wr_data;
				stt_pkg::REG_WEEKDAY_MASK:      cfg_q.weekday_mask      <= wr_data[6:0];
				stt_pkg::REG_REPEAT_COUNT:      cfg_q.repeat_count      <= wr_data[16:0];
				stt_pkg::REG_CADENCE_SECONDS:   cfg_q.cadence_seconds   <= wr_data;
				stt_pkg::REG_START_IMMEDIATELY: cfg_q.start_immediately <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/stt_state.sv -----
// ----------------------------------------------------------------------------
// Trigger state and evaluation
// Holds the repeat, fire and timer state and evaluates one item per cycle while advance is high.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_state (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire stt_pkg::cfg_t   cfg,
	input  wire stt_pkg::item_t  item,
	input  wire logic            advance,
	output stt_pkg::result_t     result
);

	logic signed [stt_pkg::RepW-1:0] repeats_q, repeats_d;
	logic [stt_pkg::SecW-1:0]        fired_q, fired_d;
	logic [stt_pkg::SecW-1:0]        base_q, base_d;
	logic                            window_q, window_d;

	logic                      before_start, after_end, day_ok, gate_ok;
	logic                      cadence_ok, fire;
	logic [stt_pkg::SecW-1:0]  elapsed;
	logic [7:0]                mask_ext;

	// Window, weekday and cadence checks
	always_comb begin
		mask_ext     = {1'b0, cfg.weekday_mask};
		before_start = cfg.limit_enables[0] && (item.current_seconds < cfg.window_start);
		after_end    = cfg.limit_enables[1] && (item.current_seconds > cfg.window_end);
		day_ok       = (cfg.weekday_mask == '0) || mask_ext[item.day_of_week];
		gate_ok      = !before_start && !after_end && day_ok;
		elapsed      = item.current_seconds - base_q;
		cadence_ok   = (cfg.start_immediately && (fired_q == '0))
		            || (cfg.cadence_seconds == '0)
		            || (elapsed >= cfg.cadence_seconds);
		fire         = (item.action == stt_pkg::ACT_EVALUATE) && cfg.task_enable
		            && gate_ok && (repeats_q != '0) && cadence_ok;
	end

	// Next state
	always_comb begin
		repeats_d = repeats_q;
		fired_d   = fired_q;
		base_d    = base_q;
		window_d  = window_q;
		if (item.action == stt_pkg::ACT_RESTART) begin
			repeats_d = cfg.repeat_count[stt_pkg::RepW-1] ? '1 : cfg.repeat_count;
			fired_d   = '0;
			base_d    = item.current_seconds;
		end else if (cfg.task_enable) begin
			// Window flag follows the first failing or the passing check
			if (before_start || after_end) begin
				window_d = 1'b0;
			end else if (cfg.limit_enables != 2'b00) begin
				window_d = 1'b1;
			end
			// Rebase before the window, and on a disallowed day unless after the window end
			if (before_start || (!after_end && !day_ok)) begin
				base_d = item.current_seconds;
			end
			if (fire) begin
				if (!repeats_q[stt_pkg::RepW-1]) begin
					repeats_d = repeats_q - stt_pkg::RepW'(1);
				end
				base_d = item.current_seconds;
				if (fired_q != '1) begin
					fired_d = fired_q + stt_pkg::SecW'(1);
				end
			end
		end
	end

	// Commit on each advancing item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeats_q <= '0;
			fired_q   <= '0;
			base_q    <= '0;
			window_q  <= 1'b0;
		end else if (advance) begin
			repeats_q <= repeats_d;
			fired_q   <= fired_d;
			base_q    <= base_d;
			window_q  <= window_d;
		end
	end

	assign result.fire         = fire;
	assign result.in_window    = window_d;
	assign result.repeats_left = repeats_d;
	assign result.fires_done   = fired_d;

endmodule

`default_nettype wire

// ----- rtl/scheduled_task_trigger_unit.sv -----
// Path: an item is registered in the input stage, evaluated, and its result is
// registered in the result register before it is presented.
// Throughput: one item per cycle while the result register is free or being taken.
// The input stage buffers one item while the result register is stalled.
// Reset (arst_n low) clears configuration, repeat, fire and timer state and
// empties both stages.
// ----------------------------------------------------------------------------
// Scheduled task trigger unit
// Stream wrapper: input stage, evaluation and registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module scheduled_task_trigger_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [stt_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [stt_pkg::CfgDatW-1:0]   cfg_data,
	// input stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// current_seconds[31:0], day_of_week[34:32], zero pad[39:35]
	input  wire logic [stt_pkg::InDataW-1:0]   s_tdata,
	// action[0]
	input  wire logic [0:0]                    s_tuser,
	// result stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// fire[0], in_window[1], repeats_left[18:2], fires_done[50:19], zero pad[55:51]
	output logic [stt_pkg::OutDataW-1:0]       m_tdata
);

	stt_pkg::cfg_t    cfg;
	stt_pkg::item_t   item_s1;
	stt_pkg::result_t res_c, res_s2;
	logic             valid_s1, valid_s2;
	logic             advance, s_xfer;

	assign cfg_ready = 1'b1;

	stt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Move the staged item on when the result register is free or being taken
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_xfer   = s_tvalid && s_tready;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			item_s1.action          <= stt_pkg::action_t'(s_tuser[0]);
			item_s1.current_seconds <= s_tdata[31:0];
			item_s1.day_of_week     <= s_tdata[34:32];
		end
	end

	stt_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.advance (advance),
		.result  (res_c)
	);

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, res_s2.fires_done, res_s2.repeats_left,
	                   res_s2.in_window, res_s2.fire};

`ifndef ASSERT_OFF
	// A staged item is never dropped while the result side stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input stage lost an item");

	// A restart never fires and clears the fire count
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.action == stt_pkg::ACT_RESTART)
		|=> (!res_s2.fire && res_s2.fires_done == '0))
		else $error("restart produced a fire or kept the count");

	// A fire always leaves a nonzero fire count
	a_fire_count: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.fire) |-> (res_s2.fires_done != '0))
		else $error("fire with zero count");

	// A waiting result is overwritten only when it is taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_tready) |-> !advance)
		else $error("result register overrun");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/scheduled_task_trigger_unit_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scheduled task trigger checker
// Watches the register, input and result channels of the trigger unit, keeps
// its own model of the task's repeat, fire and cadence state, and compares
// every result transfer against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------

module scheduled_task_trigger_unit_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [stt_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [stt_pkg::CfgDatW-1:0]  cfg_data,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [stt_pkg::InDataW-1:0]  s_tdata,
	input  logic [0:0]                   s_tuser,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [stt_pkg::OutDataW-1:0] m_tdata,
	output int unsigned                  mismatch_count,
	output int unsigned                  awaiting,
	output int unsigned                  results_seen,
	output int unsigned                  fires_seen
);

	// Register copy and task state as the unit should hold them
	stt_pkg::cfg_t                   reg_set;
	logic signed [stt_pkg::RepW-1:0] rep_left;
	logic [stt_pkg::SecW-1:0]        fire_tally;
	logic [stt_pkg::SecW-1:0]        cadence_base;
	logic                            window_seen;

	stt_pkg::result_t expected_results[$];

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		// keep the log short when the unit is badly broken
		if (mismatch_count < 40) begin
			$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
		end
		mismatch_count++;
	endtask

	// Advance the task state by one item and return the result it should give
	task automatic predict_trigger(input stt_pkg::item_t it, output stt_pkg::result_t res);
		logic                     allowed;
		logic [7:0]               day_bit;
		logic [stt_pkg::SecW-1:0] since_fire;
		allowed = 1'b0;
		if (it.action == stt_pkg::ACT_RESTART) begin
			rep_left     = reg_set.repeat_count[stt_pkg::RepW-1] ? -17'sd1
			                                                     : reg_set.repeat_count;
			fire_tally   = '0;
			cadence_base = it.current_seconds;
		end else if (reg_set.task_enable) begin
			allowed = 1'b1;
			// window start: too early rebases the cadence timer
			if (reg_set.limit_enables[0]) begin
				if (it.current_seconds < reg_set.window_start) begin
					window_seen  = 1'b0;
					cadence_base = it.current_seconds;
					allowed      = 1'b0;
				end else begin
					window_seen = 1'b1;
				end
			end
			// window end: too late leaves the timer alone
			if (allowed && reg_set.limit_enables[1]) begin
				if (it.current_seconds > reg_set.window_end) begin
					window_seen = 1'b0;
					allowed     = 1'b0;
				end else begin
					window_seen = 1'b1;
				end
			end
			// weekday seven sets no bit, so it fails any non-empty mask
			if (allowed && reg_set.weekday_mask != '0) begin
				day_bit = 8'd1 << it.day_of_week;
				if ((day_bit[stt_pkg::MaskW-1:0] & reg_set.weekday_mask) == '0) begin
					cadence_base = it.current_seconds;
					allowed      = 1'b0;
				end
			end
			if (allowed && rep_left == 17'sd0) begin
				allowed = 1'b0;
			end
			// elapsed time wraps, so a clock running backwards looks long
			if (allowed && !(reg_set.start_immediately && fire_tally == '0)
					&& reg_set.cadence_seconds != '0) begin
				since_fire = it.current_seconds - cadence_base;
				if (since_fire < reg_set.cadence_seconds) begin
					allowed = 1'b0;
				end
			end
			if (allowed) begin
				if (rep_left > 17'sd0) begin
					rep_left = rep_left - 17'sd1;
				end
				cadence_base = it.current_seconds;
				if (fire_tally != '1) begin
					fire_tally = fire_tally + 32'd1;
				end
			end
		end
		res.fire         = allowed;
		res.in_window    = window_seen;
		res.repeats_left = rep_left;
		res.fires_done   = fire_tally;
	endtask

	// Track transfers on all three channels
	always @(posedge clk or negedge arst_n) begin : watch
		stt_pkg::item_t   it;
		stt_pkg::result_t want;
		stt_pkg::result_t got;
		if (!arst_n) begin
			reg_set        = '0;
			rep_left       = '0;
			fire_tally     = '0;
			cadence_base   = '0;
			window_seen    = 1'b0;
			expected_results.delete();
			mismatch_count = 0;
			awaiting       = 0;
			results_seen   = 0;
			fires_seen     = 0;
		end else begin
			// register write
			if (cfg_valid && cfg_ready) begin
				case (stt_pkg::cfg_reg_t'(cfg_index))
					stt_pkg::REG_TASK_ENABLE:
						reg_set.task_enable = cfg_data[0];
					stt_pkg::REG_LIMIT_ENABLES:
						reg_set.limit_enables = cfg_data[1:0];
					stt_pkg::REG_WINDOW_START:
						reg_set.window_start = cfg_data;
					stt_pkg::REG_WINDOW_END:
						reg_set.window_end = cfg_data;
					stt_pkg::REG_WEEKDAY_MASK:
						reg_set.weekday_mask = cfg_data[stt_pkg::MaskW-1:0];
					stt_pkg::REG_REPEAT_COUNT:
						reg_set.repeat_count = cfg_data[stt_pkg::RepW-1:0];
					stt_pkg::REG_CADENCE_SECONDS:
						reg_set.cadence_seconds = cfg_data;
					stt_pkg::REG_START_IMMEDIATELY:
						reg_set.start_immediately = cfg_data[0];
					default: ;
				endcase
			end
			// input transfer: predict its result
			if (s_tvalid && s_tready) begin
				it.action          = stt_pkg::action_t'(s_tuser[0]);
				it.current_seconds = s_tdata[31:0];
				it.day_of_week     = s_tdata[34:32];
				predict_trigger(it, want);
				expected_results.push_back(want);
			end
			// result transfer: compare with the oldest prediction
			if (m_tvalid && m_tready) begin
				got.fire         = m_tdata[0];
				got.in_window    = m_tdata[1];
				got.repeats_left = m_tdata[18:2];
				got.fires_done   = m_tdata[50:19];
				results_seen++;
				if (got.fire) begin
					fires_seen++;
				end
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing outstanding", 64'(m_tdata), '0);
				end else begin
					want = expected_results.pop_front();
					if (got.fire != want.fire) begin
						report_mismatch("fire", 64'(got.fire), 64'(want.fire));
					end
					if (got.in_window != want.in_window) begin
						report_mismatch("in_window", 64'(got.in_window),
							64'(want.in_window));
					end
					if (got.repeats_left != want.repeats_left) begin
						report_mismatch("repeats_left", 64'(got.repeats_left),
							64'(want.repeats_left));
					end
					if (got.fires_done != want.fires_done) begin
						report_mismatch("fires_done", 64'(got.fires_done),
							64'(want.fires_done));
					end
				end
			end
			awaiting = expected_results.size();
		end
	end

endmodule

// ----- tb/sv/scheduled_task_trigger_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scheduled task trigger unit testbench
// Drives register settings and evaluate/restart items into the trigger unit:
// a directed pass over window edges, weekday masks, repeat and cadence limits,
// then randomised settings with mostly advancing time. Both stream sides idle
// at random and the result side holds off once to fill the unit.
// ----------------------------------------------------------------------------

module scheduled_task_trigger_unit_tb;

	localparam int unsigned RandomSettings = 8;
	localparam int unsigned ItemsPerSetting = 200;
	localparam int unsigned HoldOffCycles = 96;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [stt_pkg::CfgIdxW-1:0]  cfg_index;
	logic [stt_pkg::CfgDatW-1:0]  cfg_data;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [stt_pkg::InDataW-1:0]  s_tdata;
	logic [0:0]                   s_tuser;
	logic                         m_tvalid;
	logic                         m_tready;
	logic [stt_pkg::OutDataW-1:0] m_tdata;

	int unsigned mismatch_count;
	int unsigned awaiting;
	int unsigned results_seen;
	int unsigned fires_seen;

	int unsigned   items_sent;
	int unsigned   settings_used;
	stt_pkg::cfg_t setting;
	bit            steady;
	bit            hold_off_req;

	scheduled_task_trigger_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	scheduled_task_trigger_unit_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.awaiting       (awaiting),
		.results_seen   (results_seen),
		.fires_seen     (fires_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the unit hangs
	initial begin
		#2_000_000;
		$display("scheduled_task_trigger_unit_tb: errors");
		$finish;
	end

	// Result side: random back-pressure, one long hold-off on request
	initial begin : result_sink
		bit held;
		held     = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !held) begin
				m_tready <= 1'b0;
				repeat (HoldOffCycles) @(negedge clk);
				held = 1'b1;
			end else begin
				m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 16);
			end
		end
	end

	// Write one register; valid stays high for the next write
	task automatic write_register(input stt_pkg::cfg_reg_t idx,
			input logic [stt_pkg::CfgDatW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Load the whole register set from the current setting
	task automatic write_settings();
		write_register(stt_pkg::REG_TASK_ENABLE, {31'd0, setting.task_enable});
		write_register(stt_pkg::REG_LIMIT_ENABLES, {30'd0, setting.limit_enables});
		write_register(stt_pkg::REG_WINDOW_START, setting.window_start);
		write_register(stt_pkg::REG_WINDOW_END, setting.window_end);
		write_register(stt_pkg::REG_WEEKDAY_MASK, {25'd0, setting.weekday_mask});
		write_register(stt_pkg::REG_REPEAT_COUNT, {15'd0, setting.repeat_count});
		write_register(stt_pkg::REG_CADENCE_SECONDS, setting.cadence_seconds);
		write_register(stt_pkg::REG_START_IMMEDIATELY, {31'd0, setting.start_immediately});
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Offer one item, with occasional idle cycles first; called at a falling edge
	task automatic send_item(input stt_pkg::action_t act,
			input logic [stt_pkg::SecW-1:0] secs, input logic [stt_pkg::DayW-1:0] day);
		while (!steady && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			s_tdata  <= stt_pkg::InDataW'({$urandom, $urandom});
			s_tuser  <= 1'($urandom_range(1));
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, day, secs};
		s_tuser  <= act;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
	endtask

	// Stop offering and let every outstanding result drain
	task automatic drain_results();
		int unsigned waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (awaiting != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (6) @(negedge clk);
	endtask

	initial begin : stimulus
		logic [stt_pkg::SecW-1:0] now_s;
		logic [stt_pkg::SecW-1:0] secs;
		logic [stt_pkg::DayW-1:0] day;
		stt_pkg::action_t         act;
		int unsigned              roll;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		steady       = 1'b0;
		hold_off_req = 1'b0;
		items_sent   = 0;
		settings_used = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// disabled after reset: evaluation reports stored state only
		send_item(stt_pkg::ACT_EVALUATE, 32'd100, 3'd1);
		send_item(stt_pkg::ACT_RESTART, 32'd100, 3'd1);
		send_item(stt_pkg::ACT_EVALUATE, 32'd200, 3'd1);
		drain_results();

		// window 1000..5000, weekdays only, three repeats, cadence 100
		setting.task_enable       = 1'b1;
		setting.limit_enables     = 2'b11;
		setting.window_start      = 32'd1000;
		setting.window_end        = 32'd5000;
		setting.weekday_mask      = 7'b0111110;
		setting.repeat_count      = 17'sd3;
		setting.cadence_seconds   = 32'd100;
		setting.start_immediately = 1'b1;
		write_settings();
		send_item(stt_pkg::ACT_RESTART, 32'd900, 3'd1);
		send_item(stt_pkg::ACT_EVALUATE, 32'd500, 3'd1);
		send_item(stt_pkg::ACT_EVALUATE, 32'd1000, 3'd1);
		send_item(stt_pkg::ACT_EVALUATE, 32'd1050, 3'd1);
		send_item(stt_pkg::ACT_EVALUATE, 32'd1100, 3'd1);
		send_item(stt_pkg::ACT_EVALUATE, 32'd1250, 3'd0);
		send_item(stt_pkg::ACT_EVALUATE, 32'd1300, 3'd7);
		send_item(stt_pkg::ACT_EVALUATE, 32'd1400, 3'd3);
		send_item(stt_pkg::ACT_EVALUATE, 32'd2000, 3'd3);
		send_item(stt_pkg::ACT_EVALUATE, 32'd5001, 3'd3);
		send_item(stt_pkg::ACT_EVALUATE, 32'd5000, 3'd3);
		send_item(stt_pkg::ACT_RESTART, 32'd5000, 3'd3);
		send_item(stt_pkg::ACT_EVALUATE, 32'd0, 3'd2);
		send_item(stt_pkg::ACT_EVALUATE, 32'hFFFF_FFFF, 3'd6);
		drain_results();

		// no window, any day, repeat forever, longest cadence
		setting.limit_enables     = 2'b00;
		setting.window_start      = 32'hFFFF_FFFF;
		setting.window_end        = 32'd0;
		setting.weekday_mask      = 7'd0;
		setting.repeat_count      = -17'sd1;
		setting.cadence_seconds   = 32'hFFFF_FFFF;
		setting.start_immediately = 1'b0;
		write_settings();
		send_item(stt_pkg::ACT_RESTART, 32'd10, 3'd0);
		send_item(stt_pkg::ACT_EVALUATE, 32'd9, 3'd7);
		send_item(stt_pkg::ACT_EVALUATE, 32'd9, 3'd0);
		send_item(stt_pkg::ACT_EVALUATE, 32'd8, 3'd4);
		drain_results();

		// start check only, every day, largest finite repeat, no cadence
		setting.limit_enables     = 2'b01;
		setting.window_start      = 32'd0;
		setting.weekday_mask      = 7'h7F;
		setting.repeat_count      = 17'sd65535;
		setting.cadence_seconds   = 32'd0;
		setting.start_immediately = 1'b1;
		write_settings();
		send_item(stt_pkg::ACT_RESTART, 32'd0, 3'd0);
		send_item(stt_pkg::ACT_EVALUATE, 32'd0, 3'd6);
		send_item(stt_pkg::ACT_EVALUATE, 32'hFFFF_FFFF, 3'd5);
		drain_results();

		// disabled with live state
		setting.task_enable = 1'b0;
		write_settings();
		send_item(stt_pkg::ACT_EVALUATE, 32'd77, 3'd2);
		drain_results();

		// randomised settings, mostly advancing time around the window
		for (int unsigned p = 0; p < RandomSettings; p++) begin
			setting.task_enable   = ($urandom_range(9) != 0);
			setting.limit_enables = 2'($urandom_range(3));
			if (p == 4) begin
				setting.window_start = 32'd0;
				setting.window_end   = 32'hFFFF_FFFF;
			end else begin
				setting.window_start = $urandom;
				setting.window_end   = setting.window_start + $urandom_range(500, 8000);
			end
			roll = $urandom_range(3);
			setting.weekday_mask = (roll == 0) ? 7'd0 : (roll == 1) ? 7'h7F : 7'($urandom);
			case ($urandom_range(5))
				0: setting.repeat_count = -17'sd1;
				1: setting.repeat_count = 17'h10000;
				2: setting.repeat_count = 17'sd0;
				3: setting.repeat_count = 17'($urandom_range(1, 20));
				4: setting.repeat_count = 17'sd65535;
				default: setting.repeat_count = 17'($urandom);
			endcase
			case ($urandom_range(4))
				0: setting.cadence_seconds = 32'd0;
				1: setting.cadence_seconds = $urandom_range(1, 60);
				2: setting.cadence_seconds = 32'hFFFF_FFFF;
				default: setting.cadence_seconds = $urandom_range(1, 400);
			endcase
			setting.start_immediately = 1'($urandom_range(1));
			write_settings();
			hold_off_req = (p == 1);
			steady       = (p == 3);
			now_s = setting.window_start - $urandom_range(0, 100);
			send_item(stt_pkg::ACT_RESTART, now_s, 3'($urandom_range(7)));
			for (int unsigned n = 0; n < ItemsPerSetting; n++) begin
				roll = $urandom_range(99);
				act  = (roll < 5) ? stt_pkg::ACT_RESTART : stt_pkg::ACT_EVALUATE;
				// a few items jump to an arbitrary time without moving the clock
				if (roll >= 5 && roll < 13) begin
					secs = $urandom;
				end else begin
					now_s = now_s + $urandom_range(0, 40);
					secs  = now_s;
				end
				day = 3'($urandom_range(7));
				// favour allowed days so the cadence and repeat limits get exercised
				if (setting.weekday_mask != '0 && $urandom_range(9) < 7) begin
					while (!(day < 7 && setting.weekday_mask[day])) day = 3'($urandom_range(6));
				end
				send_item(act, secs, day);
			end
			steady = 1'b0;
			drain_results();
		end

		$display("Run covered %0d items under %0d register settings,", items_sent, settings_used);
		$display("with %0d results checked and %0d fires seen.", results_seen, fires_seen);
		if (mismatch_count == 0 && awaiting == 0) begin
			$display("scheduled_task_trigger_unit_tb: clean");
		end else begin
			$display("scheduled_task_trigger_unit_tb: errors");
		end
		$finish;
	end

endmodule
